@@ src/fms_pkg.sv @@
// Shared types and constants for the flexible multi-stack core.
package fms_pkg;

   localparam int NUM_STACKS_DEFAULT = 4;
   localparam int SLOTS_PER_STACK_DEFAULT = 8;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WALK,
      ST_SETUP,
      ST_SL_RD,
      ST_SL_WR,
      ST_ZERO,
      ST_PUSH,
      ST_POP,
      ST_RESP
   } state_type;

endpackage

@@ src/fms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/flexible_multi_stack_core.sv @@
// Flexible multi-stack core: several stacks sharing one circular slot RAM.
// NUM_STACKS stacks share NUM_STACKS * SLOTS_PER_STACK 32-bit slots in one RAM; each
// stack starts with an equal share and borrows slots from its neighbors when it fills
// up. After reset the core sweeps the RAM to zero, one slot per cycle, with req_tready
// low. Each command is worked by a small sequencer around one RAM port pair: pop and
// peek of a non-empty stack and a push into a stack with room go from accept through
// decode and a pop or push step to the reply step; a refused push, a pop or peek of an
// empty stack and an undefined command go from decode straight to the reply step. A push
// into a full stack first walks the chain of full neighbors, then slides each chain
// stack one slot forward: a setup step per stack, a read and a write step per moved
// element and a zero step that frees the stack's first slot, then the push step. One
// result beat is produced per request beat; the result register lets the next request
// be taken while the last result waits, and a second result holds the sequencer in its
// reply step until the first one is taken.
module flexible_multi_stack_core #(
   parameter int NUM_STACKS = fms_pkg::NUM_STACKS_DEFAULT,
   parameter int SLOTS_PER_STACK = fms_pkg::SLOTS_PER_STACK_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [3:0]  req_tuser,   // cmd[1:0], stack_id[3:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_value[31:0], total_count[37:32], zero[39:38]
   output logic [2:0]  rsp_tuser    // status[1:0], stack_empty[2]
);

   localparam int TOTAL = NUM_STACKS * SLOTS_PER_STACK;
   localparam int SW = $clog2(TOTAL);
   localparam int CW = $clog2(TOTAL + 1);
   localparam int AW = CW + 1;
   localparam int IW = $clog2(NUM_STACKS);

   fms_pkg::state_type state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [IW-1:0]    n_ff, n_in;
   logic [31:0]      value_ff, value_in;
   logic [IW-1:0]    walk_ff, walk_in;
   logic [IW-1:0]    last_ff, last_in;
   logic [IW-1:0]    m_ff, m_in;
   logic             grew_ff, grew_in;
   logic [CW-1:0]    moves_ff, moves_in;
   logic [SW-1:0]    src_ff, src_in;
   logic [SW-1:0]    ptr_ff, ptr_in;
   logic [31:0]      result_ff, result_in;
   logic [1:0]       status_ff, status_in;
   logic [SW-1:0]    clr_ff, clr_in;
   logic [CW-1:0]    total_ff, total_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_result_ff, rsp_result_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic [5:0]       rsp_total_ff, rsp_total_in;

   logic [SW-1:0]    start_ff [NUM_STACKS];
   logic [CW-1:0]    cap_ff [NUM_STACKS];
   logic [CW-1:0]    fill_ff [NUM_STACKS];

   logic [IW-1:0]    idx;
   logic [SW-1:0]    cur_start;
   logic [CW-1:0]    cur_cap;
   logic [CW-1:0]    cur_fill;
   logic             start_we, cap_we, fill_we;
   logic [SW-1:0]    start_wdata;
   logic [CW-1:0]    cap_wdata, fill_wdata;

   logic             ram_we;
   logic [SW-1:0]    ram_waddr, ram_raddr;
   logic [31:0]      ram_wdata, ram_rdata;

   logic [4:0]       id_w;
   logic [AW-1:0]    len;

   function automatic logic [SW-1:0] wrap(input logic [AW-1:0] x);
      logic [AW-1:0] y;
      y = x;
      if (y >= AW'(TOTAL)) begin
         y = y - AW'(TOTAL);
      end
      return SW'(y);
   endfunction

   function automatic logic [IW-1:0] next_stack(input logic [IW-1:0] s);
      return (s == IW'(NUM_STACKS - 1)) ? '0 : s + IW'(1);
   endfunction

   function automatic logic [IW-1:0] prev_stack(input logic [IW-1:0] s);
      return (s == '0) ? IW'(NUM_STACKS - 1) : s - IW'(1);
   endfunction

   fms_ram #(
      .WIDTH(32),
      .DEPTH(TOTAL)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cur_start = start_ff[idx];
   assign cur_cap = cap_ff[idx];
   assign cur_fill = fill_ff[idx];

   assign req_tready = (state_ff == fms_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_total_ff, rsp_result_ff};
   assign rsp_tuser = {rsp_empty_ff, rsp_status_ff};

   always_comb begin
      id_w = 5'(req_tuser[3:2]);
      if (id_w >= 5'(NUM_STACKS)) begin
         id_w = id_w - 5'(NUM_STACKS);
      end
   end

   always_comb begin
      case (state_ff)
         fms_pkg::ST_WALK,
         fms_pkg::ST_SETUP,
         fms_pkg::ST_SL_RD,
         fms_pkg::ST_SL_WR,
         fms_pkg::ST_ZERO: idx = walk_ff;
         default: idx = n_ff;
      endcase
   end

   assign len = (walk_ff == last_ff) ? AW'(cur_cap) : AW'(cur_cap) + AW'(1);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      n_in = n_ff;
      value_in = value_ff;
      walk_in = walk_ff;
      last_in = last_ff;
      m_in = m_ff;
      grew_in = grew_ff;
      moves_in = moves_ff;
      src_in = src_ff;
      ptr_in = ptr_ff;
      result_in = result_ff;
      status_in = status_ff;
      clr_in = clr_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_total_in = rsp_total_ff;
      start_we = 1'b0;
      cap_we = 1'b0;
      fill_we = 1'b0;
      start_wdata = cur_start;
      cap_wdata = cur_cap;
      fill_wdata = cur_fill;
      ram_we = 1'b0;
      ram_waddr = src_ff;
      ram_wdata = '0;
      ram_raddr = src_ff;

      case (state_ff)
         fms_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(TOTAL - 1)) begin
               state_in = fms_pkg::ST_IDLE;
            end
         end
         fms_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser[1:0];
               n_in = IW'(id_w);
               value_in = req_tdata;
               state_in = fms_pkg::ST_DECODE;
            end
         end
         fms_pkg::ST_DECODE: begin
            result_in = '0;
            status_in = fms_pkg::STATUS_OK;
            grew_in = 1'b0;
            m_in = '0;
            walk_in = next_stack(n_ff);
            ptr_in = wrap(AW'(cur_start) + AW'(cur_fill) - AW'(1));
            ram_raddr = wrap(AW'(cur_start) + AW'(cur_fill) - AW'(1));
            case (cmd_ff)
               fms_pkg::CMD_PUSH: begin
                  if (total_ff == CW'(TOTAL)) begin
                     status_in = fms_pkg::STATUS_FULL;
                     state_in = fms_pkg::ST_RESP;
                  end else if (cur_fill >= cur_cap) begin
                     state_in = fms_pkg::ST_WALK;
                  end else begin
                     state_in = fms_pkg::ST_PUSH;
                  end
               end
               fms_pkg::CMD_POP,
               fms_pkg::CMD_PEEK: begin
                  if (cur_fill == '0) begin
                     status_in = fms_pkg::STATUS_EMPTY;
                     state_in = fms_pkg::ST_RESP;
                  end else begin
                     state_in = fms_pkg::ST_POP;
                  end
               end
               default: begin
                  state_in = fms_pkg::ST_RESP;
               end
            endcase
         end
         fms_pkg::ST_WALK: begin
            m_in = m_ff + IW'(1);
            if (cur_fill < cur_cap || m_ff == IW'(NUM_STACKS - 2)) begin
               last_in = walk_ff;
               state_in = fms_pkg::ST_SETUP;
            end else begin
               walk_in = next_stack(walk_ff);
            end
         end
         fms_pkg::ST_SETUP: begin
            if (len > AW'(1)) begin
               moves_in = CW'(len - AW'(1));
               src_in = wrap(AW'(cur_start) + len - AW'(2));
               state_in = fms_pkg::ST_SL_RD;
            end else begin
               moves_in = '0;
               state_in = fms_pkg::ST_ZERO;
            end
         end
         fms_pkg::ST_SL_RD: begin
            ram_raddr = src_ff;
            state_in = fms_pkg::ST_SL_WR;
         end
         fms_pkg::ST_SL_WR: begin
            ram_we = 1'b1;
            ram_waddr = (src_ff == SW'(TOTAL - 1)) ? '0 : src_ff + SW'(1);
            ram_wdata = ram_rdata;
            src_in = (src_ff == '0) ? SW'(TOTAL - 1) : src_ff - SW'(1);
            moves_in = moves_ff - CW'(1);
            state_in = (moves_ff == CW'(1)) ? fms_pkg::ST_ZERO : fms_pkg::ST_SL_RD;
         end
         fms_pkg::ST_ZERO: begin
            ram_we = 1'b1;
            ram_waddr = cur_start;
            start_we = 1'b1;
            start_wdata = (cur_start == SW'(TOTAL - 1)) ? '0 : cur_start + SW'(1);
            if (walk_ff == last_ff && cur_cap != '0) begin
               cap_we = 1'b1;
               cap_wdata = cur_cap - CW'(1);
            end
            if (prev_stack(walk_ff) == n_ff) begin
               grew_in = 1'b1;
               state_in = fms_pkg::ST_PUSH;
            end else begin
               walk_in = prev_stack(walk_ff);
               state_in = fms_pkg::ST_SETUP;
            end
         end
         fms_pkg::ST_PUSH: begin
            ram_we = 1'b1;
            ram_waddr = wrap(AW'(cur_start) + AW'(cur_fill));
            ram_wdata = value_ff;
            fill_we = 1'b1;
            fill_wdata = cur_fill + CW'(1);
            if (grew_ff) begin
               cap_we = 1'b1;
               cap_wdata = cur_cap + CW'(1);
            end
            total_in = total_ff + CW'(1);
            state_in = fms_pkg::ST_RESP;
         end
         fms_pkg::ST_POP: begin
            result_in = ram_rdata;
            if (cmd_ff == fms_pkg::CMD_POP) begin
               ram_we = 1'b1;
               ram_waddr = ptr_ff;
               fill_we = 1'b1;
               fill_wdata = cur_fill - CW'(1);
               total_in = total_ff - CW'(1);
            end
            state_in = fms_pkg::ST_RESP;
         end
         fms_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_result_in = result_ff;
               rsp_status_in = status_ff;
               rsp_empty_in = (cur_fill == '0);
               rsp_total_in = 6'(total_ff);
               state_in = fms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fms_pkg::ST_CLEAR;
         clr_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            start_ff[i] <= SW'(i * SLOTS_PER_STACK);
            cap_ff[i] <= CW'(SLOTS_PER_STACK);
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (start_we) begin
            start_ff[idx] <= start_wdata;
         end
         if (cap_we) begin
            cap_ff[idx] <= cap_wdata;
         end
         if (fill_we) begin
            fill_ff[idx] <= fill_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      n_ff <= n_in;
      value_ff <= value_in;
      walk_ff <= walk_in;
      last_ff <= last_in;
      m_ff <= m_in;
      grew_ff <= grew_in;
      moves_ff <= moves_in;
      src_ff <= src_in;
      ptr_ff <= ptr_in;
      result_ff <= result_in;
      status_ff <= status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_total_ff <= rsp_total_in;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(TOTAL))
      else $error("element count exceeds slot count");

   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == fms_pkg::STATUS_FULL |->
         rsp_total_ff == 6'(TOTAL))
      else $error("full status with free slots");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == fms_pkg::STATUS_EMPTY |->
         rsp_empty_ff && rsp_result_ff == '0)
      else $error("empty status with data");

   a_move_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == fms_pkg::ST_SL_RD || state_ff == fms_pkg::ST_SL_WR |-> moves_ff != '0)
      else $error("slide step with no moves left");

   a_walk_stop: assert property (@(posedge clock) disable iff (reset)
      state_ff == fms_pkg::ST_SETUP |-> walk_ff != n_ff)
      else $error("slide reached the growing stack");

endmodule
